// File: rtl/core/pnguf_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
// Used by the channel interfaces and by every module of the block but the checker.
package pnguf_pkg;

   // Default bounds for the line buffer and row length
   localparam int MAX_ROW_PIXELS_DEF = 1024;
   localparam int MAX_ROW_BYTES_DEF  = 4096;

   // Register port widths
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BPP        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PIXELS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = 2'd2;

   // Register reset values
   localparam logic [2:0]  BPP_RESET        = 3'd4;
   localparam logic [10:0] ROW_PIXELS_RESET = 11'd1024;
   localparam logic [15:0] IMAGE_ROWS_RESET = 16'd1;

   // Filter type carried by the first byte of each row
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // Control carried from the accept stage into the reconstruct stage
   typedef struct packed {
      logic       clear;       // filter byte: clear left history, no result
      filter_type filter;
      logic [7:0] raw;
      logic       bpp4;        // 4 bytes per pixel, else 3
      logic       use_upper;   // row above exists
      logic       row_last;
      logic       image_last;
   } stage_ctl_type;

   // One result item as buffered toward the output
   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       row_last;
      logic       image_last;
   } rsp_item_type;

endpackage

// File: rtl/core/pnguf_ifs.sv
// Valid/ready channel interfaces of the PNG scanline unfilter.
// Depends on pnguf_pkg for the register port widths.
interface pnguf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   modport source(output valid, output stream_byte, input ready);
   modport sink(input valid, input stream_byte, output ready);
endinterface

interface pnguf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       row_last;
   logic       image_last;
   modport source(output valid, output pixel_byte, output row_last, output image_last,
                  input ready);
   modport sink(input valid, input pixel_byte, input row_last, input image_last,
                output ready);
endinterface

interface pnguf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pnguf_pkg::CSR_IDX_W-1:0]  index;
   logic [pnguf_pkg::CSR_DATA_W-1:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/core/pnguf_line_buf.sv
// Line buffer holding the previously reconstructed row.
// Simple dual-port memory, one write and one registered read per cycle.
module pnguf_line_buf #(
   parameter int Depth = pnguf_pkg::MAX_ROW_BYTES_DEF,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [7:0]       rd_data
);
   logic [7:0] mem [Depth];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/pnguf_recon.sv
// Byte reconstruction: predictor selection and modulo-256 add.
// Depends on pnguf_pkg for the filter type.
module pnguf_recon (
   input  pnguf_pkg::filter_type filter,
   input  logic [7:0]            raw,
   input  logic [7:0]            left,
   input  logic [7:0]            upper,
   input  logic [7:0]            upper_left,
   output logic [7:0]            pixel
);
   import pnguf_pkg::*;

   logic signed [9:0] d_bc, d_ac, d_abc;
   logic [9:0]        pa, pb, pc;
   logic [8:0]        avg_sum;
   logic [7:0]        paeth_pred;
   logic [7:0]        pred;

   // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
   always_comb begin
      d_bc  = $signed({2'b00, upper}) - $signed({2'b00, upper_left});
      d_ac  = $signed({2'b00, left}) - $signed({2'b00, upper_left});
      d_abc = d_bc + d_ac;
      pa = (d_bc  < 0) ? 10'(-d_bc)  : 10'(d_bc);
      pb = (d_ac  < 0) ? 10'(-d_ac)  : 10'(d_ac);
      pc = (d_abc < 0) ? 10'(-d_abc) : 10'(d_abc);
      if (pa <= pb && pa <= pc) begin
         paeth_pred = left;
      end else if (pb <= pc) begin
         paeth_pred = upper;
      end else begin
         paeth_pred = upper_left;
      end
   end

   assign avg_sum = {1'b0, left} + {1'b0, upper};

   // predictor by filter type
   always_comb begin
      case (filter)
         FILT_SUB:   pred = left;
         FILT_UP:    pred = upper;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth_pred;
         default:    pred = 8'd0;
      endcase
   end

   assign pixel = raw + pred;
endmodule

// File: rtl/core/pnguf_out_fifo.sv
// Three-entry output queue decoupling reconstruction from the result channel.
// Depends on pnguf_pkg for the result item type.
module pnguf_out_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pnguf_pkg::rsp_item_type push_item,
   input  logic                    pop,
   output logic                    not_empty,
   output pnguf_pkg::rsp_item_type head_item,
   output logic [1:0]              count
);
   import pnguf_pkg::*;

   localparam logic [1:0] LastSlot = 2'd2;

   rsp_item_type slot_ff [3];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_pop;

   assign do_pop = pop && (count_ff != 2'd0);

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign count     = count_ff;
endmodule

// File: rtl/core/png_scanline_unfilter.sv
// PNG scanline unfilter: rebuilds image bytes from the filtered stream.
// A data byte passes the reconstruct stage and the output queue before it appears on rsp.
// Throughput: 1 byte per cycle while the output queue has room, set by the line
//   buffer's one read and one write port; the filter byte of each row yields nothing.
// Reset clears the control state and registers; the line buffer is not
//   cleared, since its data is used only from the second row of an image on.
module png_scanline_unfilter #(
   parameter int MAX_ROW_PIXELS = pnguf_pkg::MAX_ROW_PIXELS_DEF,
   parameter int MAX_ROW_BYTES  = pnguf_pkg::MAX_ROW_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   pnguf_req_if.sink   req_ch,
   pnguf_rsp_if.source rsp_ch,
   pnguf_csr_if.sink   csr_ch
);
   import pnguf_pkg::*;

   localparam int PosW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int RowBytesW = $clog2(MAX_ROW_BYTES + 1);
   localparam logic [15:0] MaxPix   = 16'(MAX_ROW_PIXELS);
   localparam logic [17:0] MaxBytes = 18'(MAX_ROW_BYTES);

   // configuration registers
   logic [2:0]  bpp_ff;
   logic [10:0] row_pixels_ff;
   logic [15:0] image_rows_ff;

   // row control
   logic             awaiting_ff;
   filter_type       filter_ff;
   logic [PosW-1:0]  pos_ff;
   logic [15:0]      row_idx_ff;

   // reconstruct stage
   logic            s1_valid_ff;
   stage_ctl_type   s1_ctl_ff, s1_ctl_in;
   logic [PosW-1:0] s1_pos_ff;

   // left and upper-left history, newest at index 0
   logic [7:0] left_ff [4];
   logic [7:0] ul_ff   [4];

   logic                 accept;
   logic                 bpp4;
   logic [15:0]          pix_eff;
   logic [15:0]          rows_eff;
   logic [17:0]          bytes_full;
   logic [RowBytesW-1:0] row_bytes;
   logic [RowBytesW-1:0] pos_inc;
   logic                 row_end;
   logic                 img_end;
   logic [7:0]           upper_q;
   logic [7:0]           a_byte, b_byte, c_byte;
   logic [7:0]           pixel;
   logic                 push;
   rsp_item_type         push_item, head_item;
   logic [1:0]           fifo_count;
   logic                 fifo_not_empty;

   // register writes
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff        <= BPP_RESET;
         row_pixels_ff <= ROW_PIXELS_RESET;
         image_rows_ff <= IMAGE_ROWS_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_BPP:        bpp_ff        <= csr_ch.data[2:0];
            CSR_ROW_PIXELS: row_pixels_ff <= csr_ch.data[10:0];
            CSR_IMAGE_ROWS: image_rows_ff <= csr_ch.data;
            default:        ;
         endcase
      end
   end

   // effective geometry
   always_comb begin
      bpp4     = (bpp_ff > 3'd3);
      pix_eff  = (row_pixels_ff == 11'd0) ? 16'd1 : {5'd0, row_pixels_ff};
      if (pix_eff > MaxPix) begin
         pix_eff = MaxPix;
      end
      rows_eff = (image_rows_ff == 16'd0) ? 16'd1 : image_rows_ff;
      bytes_full = bpp4 ? {pix_eff, 2'b00} : ({2'b00, pix_eff} + {1'b0, pix_eff, 1'b0});
      if (bytes_full > MaxBytes) begin
         bytes_full = MaxBytes;
      end
      row_bytes = bytes_full[RowBytesW-1:0];
   end

   // accept stage: row position and end-of-row decisions
   assign req_ch.ready = ({1'b0, fifo_count} + {2'b00, s1_valid_ff}) <= 3'd2;
   assign accept  = req_ch.valid && req_ch.ready;
   assign pos_inc = RowBytesW'(pos_ff) + RowBytesW'(1);
   assign row_end = (pos_inc >= row_bytes);
   assign img_end = row_end && (({1'b0, row_idx_ff} + 17'd1) >= {1'b0, rows_eff});

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
         filter_ff   <= FILT_NONE;
         pos_ff      <= '0;
         row_idx_ff  <= 16'd0;
      end else if (accept) begin
         if (awaiting_ff) begin
            filter_ff   <= (req_ch.stream_byte <= 8'd4)
                              ? filter_type'(req_ch.stream_byte[2:0]) : FILT_NONE;
            pos_ff      <= '0;
            awaiting_ff <= 1'b0;
         end else if (row_end) begin
            awaiting_ff <= 1'b1;
            pos_ff      <= '0;
            row_idx_ff  <= img_end ? 16'd0 : row_idx_ff + 16'd1;
         end else begin
            pos_ff <= pos_ff + PosW'(1);
         end
      end
   end

   // hand the item to the reconstruct stage
   always_comb begin
      s1_ctl_in.clear      = awaiting_ff;
      s1_ctl_in.filter     = filter_ff;
      s1_ctl_in.raw        = req_ch.stream_byte;
      s1_ctl_in.bpp4       = bpp4;
      s1_ctl_in.use_upper  = (row_idx_ff != 16'd0);
      s1_ctl_in.row_last   = row_end;
      s1_ctl_in.image_last = img_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff <= s1_ctl_in;
         s1_pos_ff <= pos_ff;
      end
   end

   // line buffer: read at accept, write back at reconstruct; the same entry
   // is read again only a full row later, so no forwarding is needed
   pnguf_line_buf #(
      .Depth(MAX_ROW_BYTES),
      .AddrW(PosW)
   ) u_line_buf (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(s1_pos_ff),
      .wr_data(pixel),
      .rd_en  (accept && !awaiting_ff),
      .rd_addr(pos_ff),
      .rd_data(upper_q)
   );

   // reconstruct stage
   assign b_byte = s1_ctl_ff.use_upper ? upper_q : 8'd0;
   assign a_byte = s1_ctl_ff.bpp4 ? left_ff[3] : left_ff[2];
   assign c_byte = s1_ctl_ff.bpp4 ? ul_ff[3]   : ul_ff[2];
   assign push   = s1_valid_ff && !s1_ctl_ff.clear;

   pnguf_recon u_recon (
      .filter    (s1_ctl_ff.filter),
      .raw       (s1_ctl_ff.raw),
      .left      (a_byte),
      .upper     (b_byte),
      .upper_left(c_byte),
      .pixel     (pixel)
   );

   // history shift: cleared at each filter byte
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            left_ff[i] <= 8'd0;
            ul_ff[i]   <= 8'd0;
         end
      end else if (s1_valid_ff) begin
         if (s1_ctl_ff.clear) begin
            for (int i = 0; i < 4; i++) begin
               left_ff[i] <= 8'd0;
               ul_ff[i]   <= 8'd0;
            end
         end else begin
            for (int i = 3; i > 0; i--) begin
               left_ff[i] <= left_ff[i-1];
               ul_ff[i]   <= ul_ff[i-1];
            end
            left_ff[0] <= pixel;
            ul_ff[0]   <= b_byte;
         end
      end
   end

   // output queue
   always_comb begin
      push_item.pixel_byte = pixel;
      push_item.row_last   = s1_ctl_ff.row_last;
      push_item.image_last = s1_ctl_ff.image_last;
   end

   pnguf_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (rsp_ch.ready),
      .not_empty(fifo_not_empty),
      .head_item(head_item),
      .count    (fifo_count)
   );

   assign rsp_ch.valid      = fifo_not_empty;
   assign rsp_ch.pixel_byte = head_item.pixel_byte;
   assign rsp_ch.row_last   = head_item.row_last;
   assign rsp_ch.image_last = head_item.image_last;
endmodule

// File: rtl/core/pnguf_checker.sv
// Port-level checks for the PNG scanline unfilter, bound to the top level.
// Sees only the top level's channel ports.
module pnguf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_byte,
   input logic       rsp_row_last,
   input logic       rsp_image_last
);
   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_byte)
         && $stable(rsp_row_last) && $stable(rsp_image_last))
      else $error("rsp item changed while stalled");

   // the last byte of an image is also the last byte of its row
   a_image_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_last |-> rsp_row_last)
      else $error("image_last without row_last");

   // output queue is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a newly valid result traces back to an accepted item
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp item without a matching accepted item");
endmodule

bind png_scanline_unfilter pnguf_checker u_pnguf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_pixel_byte(rsp_ch.pixel_byte),
   .rsp_row_last  (rsp_ch.row_last),
   .rsp_image_last(rsp_ch.image_last)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for png_scanline_unfilter: directed script, then random images.
// Depends on pnguf_pkg, the pnguf channel interfaces and the RTL of the block.
module testbench;
   import pnguf_pkg::*;

   localparam int RANDOM_ITEMS   = 1300;
   localparam int SETTLE_CYCLES  = 8;     // exceeds the block's latency, covers a filter byte in flight
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 500;
   localparam int HOLD_AFTER     = 400;
   localparam int SCRIPT_LEN     = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // unmapped index, ignored

   typedef enum logic [1:0] {
      STEP_CSR,     // register write
      STEP_BYTE,    // stream byte, checked against the predictor
      STEP_TYPED    // stream byte with the expected pixel given in the row
   } step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      rsp_item_type          want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pnguf_req_if req_if ();
   pnguf_rsp_if rsp_if ();
   pnguf_csr_if csr_if ();

   png_scanline_unfilter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #2 clock = ~clock;

   // Unfilter predictor state and its copy of the registers
   logic [7:0]  line_mem [MAX_ROW_BYTES_DEF];
   filter_type  cur_filter  = FILT_NONE;
   int          pos         = 0;
   bit          want_filter = 1'b1;
   int          row_idx     = 0;
   logic [7:0]  left_q [4]   = '{default: 8'h00};
   logic [7:0]  upleft_q [4] = '{default: 8'h00};
   bit          image_closed = 1'b0;
   logic [2:0]  cfg_bpp     = BPP_RESET;
   logic [10:0] cfg_pixels  = ROW_PIXELS_RESET;
   logic [15:0] cfg_rows    = IMAGE_ROWS_RESET;

   rsp_item_type pending_pixels [$];

   int fail_count    = 0;
   int byte_count    = 0;
   int pixel_count   = 0;
   int write_count   = 0;
   int setting_count = 0;
   int burst_left    = 0;
   int stall_cycles  = 0;
   int cyc           = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   function automatic int eff_pixels();
      if (cfg_pixels == 0)
         return 1;
      return (cfg_pixels > MAX_ROW_PIXELS_DEF) ? MAX_ROW_PIXELS_DEF : int'(cfg_pixels);
   endfunction

   function automatic int eff_rows();
      return (cfg_rows == 0) ? 1 : int'(cfg_rows);
   endfunction

   function automatic int abs_gap(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Rebuilds one stream byte; returns 1 when it yields a pixel byte
   function automatic bit unfilter_step(input logic [7:0] raw, output rsp_item_type item);
      int bpp, row_len, a, b, c, p, pa, pb, pc, pred;
      logic [7:0] value;
      bit row_end, img_end;
      bpp     = (cfg_bpp <= 3) ? 3 : 4;
      row_len = eff_pixels() * bpp;
      if (row_len > MAX_ROW_BYTES_DEF)
         row_len = MAX_ROW_BYTES_DEF;
      item = '0;

      // filter byte: latch type, clear history
      if (want_filter) begin
         cur_filter  = (raw <= 4) ? filter_type'(raw[2:0]) : FILT_NONE;
         pos         = 0;
         want_filter = 1'b0;
         for (int i = 0; i < 4; i++) begin
            left_q[i]   = 8'h00;
            upleft_q[i] = 8'h00;
         end
         return 1'b0;
      end

      a = left_q[bpp-1];
      c = upleft_q[bpp-1];
      b = (row_idx != 0 && pos < MAX_ROW_BYTES_DEF) ? int'(line_mem[pos]) : 0;

      case (cur_filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = (a + b) >> 1;
         FILT_PAETH: begin
            p  = a + b - c;
            pa = abs_gap(p - a);
            pb = abs_gap(p - b);
            pc = abs_gap(p - c);
            if (pa <= pb && pa <= pc)
               pred = a;
            else if (pb <= pc)
               pred = b;
            else
               pred = c;
         end
         default:    pred = 0;
      endcase
      value = 8'(int'(raw) + pred);

      if (pos < MAX_ROW_BYTES_DEF)
         line_mem[pos] = value;
      for (int i = 3; i > 0; i--) begin
         left_q[i]   = left_q[i-1];
         upleft_q[i] = upleft_q[i-1];
      end
      left_q[0]   = value;
      upleft_q[0] = 8'(b);

      row_end = (pos + 1 >= row_len);
      img_end = row_end && (row_idx + 1 >= eff_rows());
      if (row_end) begin
         want_filter = 1'b1;
         pos         = 0;
         row_idx     = img_end ? 0 : ((row_idx + 1) & 16'hFFFF);
      end else begin
         pos = (pos + 1) & 13'h1FFF;
      end
      if (img_end)
         image_closed = 1'b1;

      item.pixel_byte = value;
      item.row_last   = row_end;
      item.image_last = img_end;
      return 1'b1;
   endfunction

   // Offer one stream byte in bursts with random gaps; predict on acceptance
   task automatic put_byte(input logic [7:0] raw, input bit typed, input rsp_item_type typed_item);
      rsp_item_type item;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.stream_byte <= raw;
      do @(posedge clock); while (!req_if.ready);
      byte_count++;
      if (unfilter_step(raw, item))
         pending_pixels.push_back(typed ? typed_item : item);
   endtask

   // Register write, only once the block has drained
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      write_count++;
      case (idx)
         CSR_BPP:        cfg_bpp    = data[2:0];
         CSR_ROW_PIXELS: cfg_pixels = data[10:0];
         CSR_IMAGE_ROWS: cfg_rows   = data;
         default: ;
      endcase
   endtask

   // Send bytes until the image closes; optionally shrink the setting partway
   task automatic send_image(input int cut_at);
      int sent;
      logic [7:0] raw;
      sent = 0;
      image_closed = 1'b0;
      while (!image_closed) begin
         // shrinking only: rows never read line buffer entries left unwritten
         if (sent == cut_at) begin
            case ($urandom_range(0, 2))
               0:       csr_write(CSR_IMAGE_ROWS, 16'($urandom_range(0, eff_rows())));
               1:       csr_write(CSR_ROW_PIXELS,
                                  {5'($urandom), 11'($urandom_range(0, eff_pixels()))});
               default: csr_write(CSR_BPP, {13'($urandom), 3'($urandom_range(0, 3))});
            endcase
         end
         if (want_filter) begin
            raw = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 255))
                                              : 8'($urandom_range(0, 4));
         end else begin
            case ($urandom_range(0, 9))
               0:       raw = 8'h00;
               1:       raw = 8'hFF;
               default: raw = 8'($urandom_range(0, 255));
            endcase
         end
         put_byte(raw, 1'b0, '0);
         sent++;
      end
   endtask

   // Result checker and receiver stall pattern
   always @(posedge clock) begin
      rsp_item_type want;
      cyc++;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         pixel_count++;
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel item: pixel_byte %02h", rsp_if.pixel_byte);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_if.pixel_byte !== want.pixel_byte) begin
               $error("pixel_byte: expected %02h, got %02h", want.pixel_byte, rsp_if.pixel_byte);
               fail_count++;
            end
            if (rsp_if.row_last !== want.row_last) begin
               $error("row_last: expected %0b, got %0b", want.row_last, rsp_if.row_last);
               fail_count++;
            end
            if (rsp_if.image_last !== want.image_last) begin
               $error("image_last: expected %0b, got %0b", want.image_last, rsp_if.image_last);
               fail_count++;
            end
         end
      end

      // one long hold-off while the sender is offering, to back up the input
      if (!hold_done && pixel_count >= HOLD_AFTER && req_if.valid) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         case ((cyc / 128) % 4)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            2:       rsp_if.ready <= ((cyc % 8) >= 3);
            default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $error("no item accepted for %0d cycles", stall_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      script_row_type script [SCRIPT_LEN];
      int directed_items;
      int cut;

      req_if.valid       = 1'b0;
      req_if.stream_byte = 8'h00;
      rsp_if.ready       = 1'b1;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;

      script = '{
         // zero registers act as 3 bpp, 1 pixel, 1 row; unknown filter acts as none
         '{STEP_CSR,   CSR_BPP,        16'hFFF8, '0},
         '{STEP_CSR,   CSR_ROW_PIXELS, 16'hF800, '0},
         '{STEP_CSR,   CSR_IMAGE_ROWS, 16'h0000, '0},
         '{STEP_CSR,   CSR_SPARE,      16'hFFFF, '0},
         '{STEP_BYTE,  '0, 16'h00FF, '0},
         '{STEP_TYPED, '0, 16'h00FF, {8'hFF, 1'b0, 1'b0}},
         '{STEP_TYPED, '0, 16'h0000, {8'h00, 1'b0, 1'b0}},
         '{STEP_TYPED, '0, 16'h0080, {8'h80, 1'b1, 1'b1}},
         // RGB, 2 pixels, row count at its maximum
         '{STEP_CSR,   CSR_BPP,        16'h0003, '0},
         '{STEP_CSR,   CSR_ROW_PIXELS, 16'h0002, '0},
         '{STEP_CSR,   CSR_IMAGE_ROWS, 16'hFFFF, '0},
         // sub on the first row, with modulo-256 wrap
         '{STEP_BYTE,  '0, {13'd0, FILT_SUB}, '0},
         '{STEP_TYPED, '0, 16'h0001, {8'h01, 1'b0, 1'b0}},
         '{STEP_TYPED, '0, 16'h0002, {8'h02, 1'b0, 1'b0}},
         '{STEP_TYPED, '0, 16'h0003, {8'h03, 1'b0, 1'b0}},
         '{STEP_TYPED, '0, 16'h00FE, {8'hFF, 1'b0, 1'b0}},
         '{STEP_TYPED, '0, 16'h00FF, {8'h01, 1'b0, 1'b0}},
         '{STEP_TYPED, '0, 16'h0080, {8'h83, 1'b1, 1'b0}},
         '{STEP_BYTE,  '0, {13'd0, FILT_UP}, '0},
         '{STEP_BYTE,  '0, 16'h0000, '0},
         '{STEP_BYTE,  '0, 16'h00FF, '0},
         '{STEP_BYTE,  '0, 16'h007F, '0},
         '{STEP_BYTE,  '0, 16'h0080, '0},
         '{STEP_BYTE,  '0, 16'h0001, '0},
         '{STEP_BYTE,  '0, 16'h00FE, '0},
         '{STEP_BYTE,  '0, {13'd0, FILT_AVG}, '0},
         '{STEP_BYTE,  '0, 16'h00FF, '0},
         '{STEP_BYTE,  '0, 16'h00FF, '0},
         '{STEP_BYTE,  '0, 16'h0000, '0},
         '{STEP_BYTE,  '0, 16'h0000, '0},
         '{STEP_BYTE,  '0, 16'h0080, '0},
         '{STEP_BYTE,  '0, 16'h0001, '0},
         // row count cut below the current row index: next row closes the image
         '{STEP_CSR,   CSR_IMAGE_ROWS, 16'h0001, '0},
         '{STEP_BYTE,  '0, {13'd0, FILT_PAETH}, '0},
         '{STEP_BYTE,  '0, 16'h0010, '0},
         '{STEP_BYTE,  '0, 16'h00F0, '0},
         '{STEP_BYTE,  '0, 16'h0005, '0},
         '{STEP_BYTE,  '0, 16'h00FB, '0},
         '{STEP_BYTE,  '0, 16'h0000, '0},
         '{STEP_BYTE,  '0, 16'h00FF, '0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script
      foreach (script[i]) begin
         if (script[i].kind == STEP_CSR)
            csr_write(script[i].idx, script[i].data);
         else
            put_byte(script[i].data[7:0], script[i].kind == STEP_TYPED, script[i].want);
      end
      directed_items = byte_count;

      // random settings, whole images per setting, mostly small rows
      while (byte_count - directed_items < RANDOM_ITEMS) begin
         setting_count++;
         csr_write(CSR_BPP, {13'($urandom), 3'($urandom_range(0, 7))});
         case ($urandom_range(0, 19))
            0:       csr_write(CSR_ROW_PIXELS, {5'($urandom), 11'd0});
            1, 2:    csr_write(CSR_ROW_PIXELS, {5'($urandom), 11'($urandom_range(13, 80))});
            default: csr_write(CSR_ROW_PIXELS, {5'($urandom), 11'($urandom_range(1, 12))});
         endcase
         csr_write(CSR_IMAGE_ROWS, 16'($urandom_range(0, 5)));
         repeat ($urandom_range(1, 3)) begin
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : -1;
            send_image(cut);
         end
      end

      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d stream bytes (%0d directed) over %0d random settings and %0d writes,",
               byte_count, directed_items, setting_count, write_count);
      $display("checked %0d pixel bytes across all five filters, unknown codes and row trims.",
               pixel_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
rtl/core/pnguf_pkg.sv
rtl/core/pnguf_ifs.sv
rtl/core/pnguf_line_buf.sv
rtl/core/pnguf_recon.sv
rtl/core/pnguf_out_fifo.sv
rtl/core/png_scanline_unfilter.sv
rtl/core/pnguf_checker.sv
sim/testbench.sv
